// File: rtl/cesc_pkg.sv
package cesc_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int MAX_RESULTS = 6;
    localparam int NB_W        = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [32:0] COUNT_MAX = 33'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;

    localparam logic [31:0] UNI_MAX  = 32'h0010_FFFF;
    localparam logic [31:0] UTF8_MAX1 = 32'h0000_007F;
    localparam logic [31:0] UTF8_MAX2 = 32'h0000_07FF;
    localparam logic [31:0] UTF8_MAX3 = 32'h0000_FFFF;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
    localparam logic [1:0] ERR_INCOMPLETE = 2'd2;

    typedef enum logic [4:0] {
        M_NORMAL = 5'd0,
        M_SLASH  = 5'd1,
        M_X0     = 5'd2,
        M_X1     = 5'd3,
        M_SU0    = 5'd4,
        M_SU1    = 5'd5,
        M_SU2    = 5'd6,
        M_SU3    = 5'd7,
        M_LU0    = 5'd8,
        M_LU1    = 5'd9,
        M_LU2    = 5'd10,
        M_LU3    = 5'd11,
        M_LU4    = 5'd12,
        M_LU5    = 5'd13,
        M_LU6    = 5'd14,
        M_LU7    = 5'd15,
        M_OCT1   = 5'd16,
        M_OCT2   = 5'd17
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic [1:0]  error_code;
        logic [15:0] total_len;
    } t_out;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [NB_W-1:0]             nb;
        logic                        last;
        logic [1:0]                  err;
        logic [15:0]                 total_len;
    } t_rec;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
        logic            ok;
    } t_enc;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

    function automatic t_enc encode_point(input logic [31:0] u);
        t_enc e;
        e = '0;
        e.ok = 1'b1;
        if (u <= UTF8_MAX1) begin
            e.len  = 3'd1;
            e.b[0] = u[7:0];
        end else if (u <= UTF8_MAX2) begin
            e.len  = 3'd2;
            e.b[0] = {3'b110, u[10:6]};
            e.b[1] = {2'b10, u[5:0]};
        end else if (u <= UTF8_MAX3) begin
            e.len  = 3'd3;
            e.b[0] = {4'b1110, u[15:12]};
            e.b[1] = {2'b10, u[11:6]};
            e.b[2] = {2'b10, u[5:0]};
        end else if (u <= UNI_MAX) begin
            e.len  = 3'd4;
            e.b[0] = {5'b11110, u[20:18]};
            e.b[1] = {2'b10, u[17:12]};
            e.b[2] = {2'b10, u[11:6]};
            e.b[3] = {2'b10, u[5:0]};
        end else begin
            e.len  = 3'd3;
            e.b[0] = REPL_B0;
            e.b[1] = REPL_B1;
            e.b[2] = REPL_B2;
            e.ok   = 1'b0;
        end
        return e;
    endfunction

endpackage

// File: rtl/cesc_front.sv
module cesc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  cesc_pkg::t_in  i_data,
    output logic           o_rec_push,
    output cesc_pkg::t_rec o_rec
);

    cesc_pkg::t_mode                r_mode, n_mode;
    logic [31:0]                    r_value, n_value;
    logic [1:0]                     r_err, n_err;
    logic [cesc_pkg::COUNT_BITS-1:0] r_count, n_count;

    logic [7:0]  c;
    logic [4:0]  hx;
    logic [1:0]  err_step;
    logic        redo;
    logic        a_put, a_enc, a_chk;
    logic [7:0]  a_byte;
    logic [31:0] a_val;
    logic        b_put;
    logic        c_put, c_enc, fin_err;
    logic [31:0] enc_in;
    cesc_pkg::t_enc enc;
    logic [cesc_pkg::MAX_RESULTS-1:0][7:0] bytes;
    logic [cesc_pkg::NB_W-1:0] pos;
    logic [32:0] sum;
    logic [31:0] cnt32;

    assign c  = i_data.in_byte;
    assign hx = cesc_pkg::hex_digit(c);

    // escape and plain decoding for one byte
    always_comb begin
        n_mode   = r_mode;
        n_value  = r_value;
        err_step = r_err;
        redo     = 1'b0;
        a_put    = 1'b0;
        a_enc    = 1'b0;
        a_chk    = 1'b0;
        a_byte   = '0;
        a_val    = '0;
        b_put    = 1'b0;
        c_put    = 1'b0;
        c_enc    = 1'b0;
        fin_err  = 1'b0;
        unique case (r_mode)
            cesc_pkg::M_NORMAL: begin
            end
            cesc_pkg::M_SLASH: begin
                n_mode = cesc_pkg::M_NORMAL;
                unique case (c)
                    "a": begin a_put = 1'b1; a_byte = 8'h07; end
                    "b": begin a_put = 1'b1; a_byte = 8'h08; end
                    "e": begin a_put = 1'b1; a_byte = cesc_pkg::CH_ESC; end
                    "f": begin a_put = 1'b1; a_byte = 8'h0C; end
                    "n": begin a_put = 1'b1; a_byte = 8'h0A; end
                    "r": begin a_put = 1'b1; a_byte = cesc_pkg::CH_CR; end
                    "t": begin a_put = 1'b1; a_byte = 8'h09; end
                    "v": begin a_put = 1'b1; a_byte = 8'h0B; end
                    "\\", "'", "\"", "?": begin
                        a_put  = 1'b1;
                        a_byte = c;
                    end
                    "x": n_mode = cesc_pkg::M_X0;
                    "u": n_mode = cesc_pkg::M_SU0;
                    "U": n_mode = cesc_pkg::M_LU0;
                    "0", "1", "2", "3", "4", "5", "6", "7": begin
                        n_value = {29'd0, c[2:0]};
                        n_mode  = cesc_pkg::M_OCT1;
                    end
                    default: begin
                        err_step = cesc_pkg::ERR_BAD_ESCAPE;
                        a_put    = (c != cesc_pkg::CH_CR);
                        a_byte   = c;
                    end
                endcase
            end
            cesc_pkg::M_X0, cesc_pkg::M_X1: begin
                if (hx[4]) begin
                    n_value = {r_value[27:0], hx[3:0]};
                    n_mode  = cesc_pkg::M_X1;
                end else begin
                    if (r_mode == cesc_pkg::M_X0) begin
                        err_step = cesc_pkg::ERR_BAD_ESCAPE;
                    end else begin
                        a_put  = 1'b1;
                        a_byte = r_value[7:0];
                    end
                    n_mode = cesc_pkg::M_NORMAL;
                    redo   = 1'b1;
                end
            end
            cesc_pkg::M_SU0, cesc_pkg::M_SU1, cesc_pkg::M_SU2, cesc_pkg::M_SU3,
            cesc_pkg::M_LU0, cesc_pkg::M_LU1, cesc_pkg::M_LU2, cesc_pkg::M_LU3,
            cesc_pkg::M_LU4, cesc_pkg::M_LU5, cesc_pkg::M_LU6, cesc_pkg::M_LU7: begin
                if (hx[4]) begin
                    n_value = {r_value[27:0], hx[3:0]};
                    if (r_mode == cesc_pkg::M_SU3 || r_mode == cesc_pkg::M_LU7) begin
                        a_enc  = 1'b1;
                        a_chk  = 1'b1;
                        a_val  = {r_value[27:0], hx[3:0]};
                        n_mode = cesc_pkg::M_NORMAL;
                    end else begin
                        n_mode = cesc_pkg::t_mode'(r_mode + 5'd1);
                    end
                end else begin
                    err_step = cesc_pkg::ERR_INCOMPLETE;
                    if (r_mode != cesc_pkg::M_SU0 && r_mode != cesc_pkg::M_LU0) begin
                        a_enc = 1'b1;
                        a_val = r_value;
                    end
                    n_mode = cesc_pkg::M_NORMAL;
                    redo   = 1'b1;
                end
            end
            cesc_pkg::M_OCT1, cesc_pkg::M_OCT2: begin
                if (c >= "0" && c <= "7") begin
                    n_value = {r_value[28:0], 3'b000} + {29'd0, c[2:0]};
                    if (r_mode == cesc_pkg::M_OCT1) begin
                        n_mode = cesc_pkg::M_OCT2;
                    end else begin
                        a_put  = 1'b1;
                        a_byte = {r_value[4:0], c[2:0]};
                        n_mode = cesc_pkg::M_NORMAL;
                    end
                end else begin
                    a_put  = 1'b1;
                    a_byte = r_value[7:0];
                    n_mode = cesc_pkg::M_NORMAL;
                    redo   = 1'b1;
                end
            end
            default: begin
                n_mode = cesc_pkg::M_NORMAL;
                redo   = 1'b1;
            end
        endcase

        if (r_mode == cesc_pkg::M_NORMAL || redo) begin
            if (c == cesc_pkg::CH_BSLASH) begin
                n_value = '0;
                n_mode  = cesc_pkg::M_SLASH;
            end else if (c != cesc_pkg::CH_CR) begin
                b_put = 1'b1;
            end
        end

        // end of string inside an escape
        if (i_data.end_of_string) begin
            unique case (n_mode)
                cesc_pkg::M_NORMAL: begin
                end
                cesc_pkg::M_X1, cesc_pkg::M_OCT1, cesc_pkg::M_OCT2: c_put = 1'b1;
                cesc_pkg::M_SU3, cesc_pkg::M_LU7: c_enc = 1'b1;
                default: fin_err = 1'b1;
            endcase
        end
    end

    assign enc_in = a_enc ? a_val : n_value;
    assign enc    = cesc_pkg::encode_point(enc_in);

    always_comb begin
        if (fin_err || (c_enc && !enc.ok)) begin
            n_err = cesc_pkg::ERR_BAD_ESCAPE;
        end else if (a_chk && !enc.ok) begin
            n_err = cesc_pkg::ERR_BAD_ESCAPE;
        end else begin
            n_err = err_step;
        end
    end

    // byte list in output order
    always_comb begin
        bytes = '0;
        pos   = '0;
        if (a_put) begin
            bytes[pos] = a_byte;
            pos        = pos + 1'b1;
        end
        if (a_enc) begin
            for (int k = 0; k < 4; k++) begin
                if (3'(k) < enc.len && pos < cesc_pkg::NB_W'(cesc_pkg::MAX_RESULTS)) begin
                    bytes[pos] = enc.b[k];
                    pos        = pos + 1'b1;
                end
            end
        end
        if (b_put && pos < cesc_pkg::NB_W'(cesc_pkg::MAX_RESULTS)) begin
            bytes[pos] = c;
            pos        = pos + 1'b1;
        end
        if (c_put && pos < cesc_pkg::NB_W'(cesc_pkg::MAX_RESULTS)) begin
            bytes[pos] = n_value[7:0];
            pos        = pos + 1'b1;
        end
        if (c_enc) begin
            for (int k = 0; k < 4; k++) begin
                if (3'(k) < enc.len && pos < cesc_pkg::NB_W'(cesc_pkg::MAX_RESULTS)) begin
                    bytes[pos] = enc.b[k];
                    pos        = pos + 1'b1;
                end
            end
        end
    end

    always_comb begin
        sum = 33'(r_count) + 33'(pos);
        if (sum > cesc_pkg::COUNT_MAX) begin
            n_count = cesc_pkg::COUNT_BITS'(cesc_pkg::COUNT_MAX);
        end else begin
            n_count = cesc_pkg::COUNT_BITS'(sum);
        end
        cnt32 = 32'(n_count);
    end

    always_comb begin
        o_rec.bytes = bytes;
        o_rec.nb    = pos;
        o_rec.last  = i_data.end_of_string;
        o_rec.err   = n_err;
        if (!i_data.end_of_string) begin
            o_rec.total_len = '0;
        end else if (cnt32 > 32'h0000_FFFF) begin
            o_rec.total_len = 16'hFFFF;
        end else begin
            o_rec.total_len = cnt32[15:0];
        end
        o_rec_push = i_accept && (pos != '0 || i_data.end_of_string);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= cesc_pkg::M_NORMAL;
            r_value <= '0;
            r_err   <= cesc_pkg::ERR_NONE;
            r_count <= '0;
        end else if (i_accept) begin
            if (i_data.end_of_string) begin
                r_mode  <= cesc_pkg::M_NORMAL;
                r_value <= '0;
                r_err   <= cesc_pkg::ERR_NONE;
                r_count <= '0;
            end else begin
                r_mode  <= n_mode;
                r_value <= n_value;
                r_err   <= n_err;
                r_count <= n_count;
            end
        end
    end

endmodule

// File: rtl/cesc_queue.sv
module cesc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cesc_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output cesc_pkg::t_rec o_head,
    output logic           o_empty
);

    cesc_pkg::t_rec r_mem [cesc_pkg::QUEUE_DEPTH];
    logic [cesc_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [cesc_pkg::QCNT_W-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == cesc_pkg::QCNT_W'(cesc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [cesc_pkg::QPTR_W-1:0] wrap_inc(
        input logic [cesc_pkg::QPTR_W-1:0] p
    );
        return (p == cesc_pkg::QPTR_W'(cesc_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/cesc_back.sv
module cesc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cesc_pkg::t_rec i_head,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    output cesc_pkg::t_out o_data,
    output logic           o_empty,
    input  logic           i_pop
);

    logic [cesc_pkg::NB_W-1:0] r_idx;
    logic [cesc_pkg::NB_W-1:0] last_idx;
    logic                      r_ovalid;
    cesc_pkg::t_out            r_out, n_out;
    logic                      load, at_last;

    assign last_idx = (i_head.nb == '0) ? '0 : i_head.nb - 1'b1;
    assign at_last  = (r_idx == last_idx);
    assign load     = !i_q_empty && (!r_ovalid || i_pop);
    assign o_q_pop  = load && at_last;
    assign o_data   = r_out;
    assign o_empty  = !r_ovalid;

    always_comb begin
        n_out.out_byte   = i_head.bytes[r_idx];
        n_out.byte_valid = (i_head.nb != '0);
        n_out.last       = i_head.last && at_last;
        n_out.error_code = i_head.err;
        n_out.total_len  = (i_head.last && at_last) ? i_head.total_len : '0;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_idx    <= at_last ? '0 : r_idx + 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/c_escape_utf8_decoder_top.sv
// C string-literal body decoder with UTF-8 output for \u and \U escapes.
// Input channel: one source byte per transfer with an end-of-string flag,
// taken when push is high and full is low.
// Result channel: one decoded byte per transfer; the oldest result sits on
// o_data while empty is low and is taken when pop is high.
// A string end always yields at least one result carrying last, the sticky
// error and the saturated decoded byte count.
// The front end decodes one input byte per cycle into a record of up to six
// output bytes and writes it into a four-entry record queue; the back end
// reads the queue and emits one result byte per cycle while the receiver
// pops, from an output register. A record passes through the queue into
// the output register, where its first result is visible and can be taken.
// The source can send one input byte per cycle while each item yields at
// most one result; an item with more results holds the back end until all
// are out, and the queue absorbs such bursts until it fills, raising full.
// When the receiver stalls, the output register holds, the queue fills and
// full stops the source; nothing is dropped.
// Reset (synchronous, active low) empties the queue and the output register
// and returns the decoder to normal mode with zero error and zero count.
module c_escape_utf8_decoder_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  cesc_pkg::t_in  i_data,
    output logic           empty,
    input  logic           pop,
    output cesc_pkg::t_out o_data
);

    logic           accept;
    logic           rec_push;
    cesc_pkg::t_rec rec;
    cesc_pkg::t_rec head;
    logic           q_empty;
    logic           q_pop;

    assign accept = push && !full;

    cesc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_data     (i_data),
        .o_rec_push (rec_push),
        .o_rec      (rec)
    );

    cesc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (rec),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_empty (q_empty)
    );

    cesc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_data    (o_data),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

// File: tb/c_escape_utf8_decoder_scoreboard.sv
`timescale 1ns / 1ps

module c_escape_utf8_decoder_scoreboard (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  logic           full,
    input  cesc_pkg::t_in  i_data,
    input  logic           empty,
    input  logic           pop,
    input  cesc_pkg::t_out o_data,
    output int             o_fail_count,
    output int             o_pending
);

    cesc_pkg::t_mode dec_mode  = cesc_pkg::M_NORMAL;
    logic [31:0]     dec_value = '0;
    logic [1:0]      dec_err   = cesc_pkg::ERR_NONE;
    logic [31:0]     dec_count = '0;

    logic [7:0]     item_bytes[$];
    cesc_pkg::t_out expected_q[$];

    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c - "0");
        end
        if (c >= "a" && c <= "f") begin
            return int'(c - "a") + 10;
        end
        if (c >= "A" && c <= "F") begin
            return int'(c - "A") + 10;
        end
        return -1;
    endfunction

    task automatic emit(input logic [7:0] b);
        item_bytes.push_back(b);
        if (dec_count < cesc_pkg::COUNT_MAX) begin
            dec_count++;
        end
    endtask

    // utf-8 bytes of a code point, replacement sequence when out of range
    task automatic emit_point(input logic [31:0] u, output bit in_range);
        in_range = 1'b1;
        if (u <= 32'h7F) begin
            emit(u[7:0]);
        end else if (u <= 32'h7FF) begin
            emit({3'b110, u[10:6]});
            emit({2'b10, u[5:0]});
        end else if (u <= 32'hFFFF) begin
            emit({4'b1110, u[15:12]});
            emit({2'b10, u[11:6]});
            emit({2'b10, u[5:0]});
        end else if (u <= cesc_pkg::UNI_MAX) begin
            emit({5'b11110, u[20:18]});
            emit({2'b10, u[17:12]});
            emit({2'b10, u[11:6]});
            emit({2'b10, u[5:0]});
        end else begin
            emit(cesc_pkg::REPL_B0);
            emit(cesc_pkg::REPL_B1);
            emit(cesc_pkg::REPL_B2);
            in_range = 1'b0;
        end
    endtask

    task automatic take_plain(input logic [7:0] c);
        if (c == cesc_pkg::CH_BSLASH) begin
            dec_value = '0;
            dec_mode  = cesc_pkg::M_SLASH;
        end else if (c != cesc_pkg::CH_CR) begin
            emit(c);
        end
    endtask

    // again is set when the byte ends the escape and is decoded as plain text
    task automatic take_escaped(input logic [7:0] c, output bit again);
        cesc_pkg::t_mode m;
        int              h;
        bit              ok;
        m     = dec_mode;
        h     = hex_val(c);
        again = 1'b0;
        if (m == cesc_pkg::M_SLASH) begin
            dec_mode = cesc_pkg::M_NORMAL;
            case (c)
                "a": emit(8'h07);
                "b": emit(8'h08);
                "e": emit(cesc_pkg::CH_ESC);
                "f": emit(8'h0C);
                "n": emit(8'h0A);
                "r": emit(cesc_pkg::CH_CR);
                "t": emit(8'h09);
                "v": emit(8'h0B);
                cesc_pkg::CH_BSLASH, "'", "\"", "?": emit(c);
                "x": dec_mode = cesc_pkg::M_X0;
                "u": dec_mode = cesc_pkg::M_SU0;
                "U": dec_mode = cesc_pkg::M_LU0;
                "0", "1", "2", "3", "4", "5", "6", "7": begin
                    dec_value = 32'(c - "0");
                    dec_mode  = cesc_pkg::M_OCT1;
                end
                default: begin
                    dec_err = cesc_pkg::ERR_BAD_ESCAPE;
                    if (c != cesc_pkg::CH_CR) begin
                        emit(c);
                    end
                end
            endcase
        end else if (m == cesc_pkg::M_X0 || m == cesc_pkg::M_X1) begin
            if (h >= 0) begin
                dec_value = (dec_value << 4) | 32'(h);
                dec_mode  = cesc_pkg::M_X1;
            end else begin
                if (m == cesc_pkg::M_X0) begin
                    dec_err = cesc_pkg::ERR_BAD_ESCAPE;
                end else begin
                    emit(dec_value[7:0]);
                end
                dec_mode = cesc_pkg::M_NORMAL;
                again    = 1'b1;
            end
        end else if (m >= cesc_pkg::M_SU0 && m <= cesc_pkg::M_LU7) begin
            if (h >= 0) begin
                dec_value = (dec_value << 4) | 32'(h);
                if (m == cesc_pkg::M_SU3 || m == cesc_pkg::M_LU7) begin
                    emit_point(dec_value, ok);
                    if (!ok) begin
                        dec_err = cesc_pkg::ERR_BAD_ESCAPE;
                    end
                    dec_mode = cesc_pkg::M_NORMAL;
                end else begin
                    dec_mode = cesc_pkg::t_mode'(m + 1);
                end
            end else begin
                dec_err = cesc_pkg::ERR_INCOMPLETE;
                if (m != cesc_pkg::M_SU0 && m != cesc_pkg::M_LU0) begin
                    emit_point(dec_value, ok);
                end
                dec_mode = cesc_pkg::M_NORMAL;
                again    = 1'b1;
            end
        end else if (m == cesc_pkg::M_OCT1 || m == cesc_pkg::M_OCT2) begin
            if (c >= "0" && c <= "7") begin
                dec_value = (dec_value << 3) + 32'(c - "0");
                if (m == cesc_pkg::M_OCT1) begin
                    dec_mode = cesc_pkg::M_OCT2;
                end else begin
                    emit(dec_value[7:0]);
                    dec_mode = cesc_pkg::M_NORMAL;
                end
            end else begin
                emit(dec_value[7:0]);
                dec_mode = cesc_pkg::M_NORMAL;
                again    = 1'b1;
            end
        end else begin
            dec_mode = cesc_pkg::M_NORMAL;
            again    = 1'b1;
        end
    endtask

    // flush of an escape still open at the end of the string
    task automatic close_string();
        bit ok;
        if (dec_mode == cesc_pkg::M_X1 || dec_mode == cesc_pkg::M_OCT1
                || dec_mode == cesc_pkg::M_OCT2) begin
            emit(dec_value[7:0]);
        end else if (dec_mode == cesc_pkg::M_SU3 || dec_mode == cesc_pkg::M_LU7) begin
            emit_point(dec_value, ok);
            if (!ok) begin
                dec_err = cesc_pkg::ERR_BAD_ESCAPE;
            end
        end else if (dec_mode != cesc_pkg::M_NORMAL) begin
            dec_err = cesc_pkg::ERR_BAD_ESCAPE;
        end
    endtask

    task automatic decode_item(input cesc_pkg::t_in it);
        bit             again;
        cesc_pkg::t_out r;
        int             n;
        logic [15:0]    len16;
        item_bytes.delete();
        if (dec_mode == cesc_pkg::M_NORMAL) begin
            take_plain(it.in_byte);
        end else begin
            take_escaped(it.in_byte, again);
            if (again) begin
                take_plain(it.in_byte);
            end
        end
        if (it.end_of_string) begin
            close_string();
        end
        len16 = (dec_count > 32'hFFFF) ? 16'hFFFF : dec_count[15:0];
        n     = item_bytes.size();
        for (int k = 0; k < n; k++) begin
            r.out_byte   = item_bytes[k];
            r.byte_valid = 1'b1;
            r.last       = it.end_of_string && (k == n - 1);
            r.error_code = dec_err;
            r.total_len  = r.last ? len16 : 16'd0;
            expected_q.push_back(r);
        end
        if (it.end_of_string && n == 0) begin
            r.out_byte   = 8'd0;
            r.byte_valid = 1'b0;
            r.last       = 1'b1;
            r.error_code = dec_err;
            r.total_len  = len16;
            expected_q.push_back(r);
        end
        if (it.end_of_string) begin
            dec_mode  = cesc_pkg::M_NORMAL;
            dec_value = '0;
            dec_err   = cesc_pkg::ERR_NONE;
            dec_count = '0;
        end
    endtask

    always @(posedge i_clk) begin
        cesc_pkg::t_out want;
        if (!i_rst_n) begin
            dec_mode  = cesc_pkg::M_NORMAL;
            dec_value = '0;
            dec_err   = cesc_pkg::ERR_NONE;
            dec_count = '0;
            expected_q.delete();
        end else begin
            if (push && !full) begin
                decode_item(i_data);
            end
            if (pop && !empty) begin
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: result transfer with nothing pending: byte=%h valid=%b",
                                 $realtime, o_data.out_byte, o_data.byte_valid);
                    end
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (o_data.out_byte !== want.out_byte
                            || o_data.byte_valid !== want.byte_valid
                            || o_data.last !== want.last
                            || o_data.error_code !== want.error_code
                            || o_data.total_len !== want.total_len) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: mismatch exp byte=%h valid=%b last=%b err=%0d len=%0d",
                                     $realtime, want.out_byte, want.byte_valid, want.last,
                                     want.error_code, want.total_len);
                            $display("%0t:          got byte=%h valid=%b last=%b err=%0d len=%0d",
                                     $realtime, o_data.out_byte, o_data.byte_valid,
                                     o_data.last, o_data.error_code, o_data.total_len);
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// File: tb/tb_c_escape_utf8_decoder_top.sv
`timescale 1ns / 1ps

module tb_c_escape_utf8_decoder_top;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          push    = 1'b0;
    logic          pop     = 1'b0;
    cesc_pkg::t_in i_data  = '0;
    logic          full;
    logic          empty;
    cesc_pkg::t_out o_data;

    int fail_count;
    int pending;
    int send_idle_pct = 30;
    int recv_idle_pct = 30;
    int stall_left    = 0;
    int items_sent    = 0;

    logic [7:0] str_buf[$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    c_escape_utf8_decoder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

    c_escape_utf8_decoder_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_data       (i_data),
        .empty        (empty),
        .pop          (pop),
        .o_data       (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pop        <= 1'b0;
        end else if ($urandom_range(99) < recv_idle_pct) begin
            stall_left <= $urandom_range(12, 0);
            pop        <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit fin);
        cesc_pkg::t_in it;
        it.in_byte       = b;
        it.end_of_string = fin;
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_buf.size(); i++) begin
            send_byte(str_buf[i], i == str_buf.size() - 1);
        end
        str_buf.delete();
    endtask

    task automatic add_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            str_buf.push_back(t[i]);
        end
    endtask

    // leading keep digits of an ndig-digit hex number, random letter case
    task automatic add_hex(input logic [31:0] v, input int ndig, input int keep);
        logic [3:0] d;
        for (int i = 0; i < keep; i++) begin
            d = v[4 * (ndig - 1 - i) +: 4];
            if (d < 4'd10) begin
                str_buf.push_back(8'("0" + d));
            end else if ($urandom_range(1)) begin
                str_buf.push_back(8'("a" + d - 4'd10));
            end else begin
                str_buf.push_back(8'("A" + d - 4'd10));
            end
        end
    endtask

    function automatic logic [31:0] rand_point(input bit wide);
        case ($urandom_range(wide ? 5 : 2))
            0:       return $urandom_range(32'h7F, 32'h0);
            1:       return $urandom_range(32'h7FF, 32'h80);
            2:       return $urandom_range(32'hFFFF, 32'h800);
            3:       return $urandom_range(32'h10FFFF, 32'h10000);
            4:       return $urandom_range(32'hFFFFFFFF, 32'h110000);
            default: return $urandom_range(1) ? cesc_pkg::UNI_MAX : cesc_pkg::UNI_MAX + 32'd1;
        endcase
    endfunction

    task automatic add_token();
        string       simple_set;
        string       known_set;
        int          pick;
        int          ndig;
        logic [7:0]  c;
        logic [31:0] v;
        bit          known;
        simple_set = "abefnrtv\\'\"?";
        known_set  = "abefnrtv\\'\"?xuU01234567";
        pick       = $urandom_range(99);
        if (pick < 30) begin
            c = 8'($urandom_range(8'h7E, 8'h20));
            str_buf.push_back((c == cesc_pkg::CH_BSLASH) ? 8'("A") : c);
        end else if (pick < 38) begin
            str_buf.push_back(8'($urandom_range(255)));
        end else if (pick < 55) begin
            str_buf.push_back(cesc_pkg::CH_BSLASH);
            str_buf.push_back(simple_set[$urandom_range(simple_set.len() - 1)]);
        end else if (pick < 65) begin
            add_text("\\x");
            add_hex($urandom, 3, $urandom_range(3));
        end else if (pick < 73) begin
            str_buf.push_back(cesc_pkg::CH_BSLASH);
            ndig = $urandom_range(3, 1);
            for (int i = 0; i < ndig; i++) begin
                str_buf.push_back(8'("0" + $urandom_range(7)));
            end
        end else if (pick < 92) begin
            ndig = (pick < 83) ? 4 : 8;
            v    = rand_point(ndig == 8);
            add_text((ndig == 4) ? "\\u" : "\\U");
            add_hex(v, ndig, ($urandom_range(4) == 0) ? $urandom_range(ndig - 1) : ndig);
        end else begin
            str_buf.push_back(cesc_pkg::CH_BSLASH);
            if ($urandom_range(4) == 0) begin
                str_buf.push_back(cesc_pkg::CH_CR);
            end else begin
                c     = 8'($urandom_range(255));
                known = 1'b0;
                for (int i = 0; i < known_set.len(); i++) begin
                    if (known_set[i] == c) begin
                        known = 1'b1;
                    end
                end
                str_buf.push_back(known ? 8'("q") : c);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // byte extremes, then an end with no decoded byte
        str_buf.push_back(8'h00);
        str_buf.push_back(8'hFF);
        send_string();
        str_buf.push_back(cesc_pkg::CH_CR);
        send_string();
        // unknown escape letters, the second one a dropped carriage return
        add_text("\\q\\");
        str_buf.push_back(cesc_pkg::CH_CR);
        send_string();
        // hex escape with no digit, then a full three-digit octal
        add_text("\\xg\\101");
        send_string();
        // unicode escape cut short by another byte
        add_text("\\u12z");
        send_string();
        // string ending inside escapes
        add_text("\\u123");
        send_string();
        add_text("\\");
        send_string();
        add_text("\\x4");
        send_string();

        while (items_sent < 170) begin
            send_idle_pct = ($urandom_range(2) == 0) ? 0 : 10 * $urandom_range(6, 1);
            recv_idle_pct = ($urandom_range(2) == 0) ? 0 : 10 * $urandom_range(6, 1);
            repeat ($urandom_range(6, 1)) add_token();
            send_string();
        end

        // closing stretch with no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_sent < 200) begin
            repeat ($urandom_range(6, 1)) add_token();
            send_string();
        end
        push <= 1'b0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
rtl/cesc_pkg.sv
rtl/cesc_front.sv
rtl/cesc_queue.sv
rtl/cesc_back.sv
rtl/c_escape_utf8_decoder_top.sv
tb/c_escape_utf8_decoder_scoreboard.sv
tb/tb_c_escape_utf8_decoder_top.sv
